FILE: rtl/nrg_pkg.sv
package nrg_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int SKEW_W = 20;
    localparam int TIME_W = 63;
    localparam int EXP_W = 64;
    localparam int NONCE_W = 64;
    localparam logic [SKEW_W-1:0] SKEW_RESET = 20'd30;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_WINDOW = 2'd1;
    localparam logic [1:0] ST_REPLAY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [NONCE_W-1:0] nonce_high;
        logic [NONCE_W-1:0] nonce_low;
        logic [TIME_W-1:0] request_time;
        logic [TIME_W-1:0] current_time;
    } req_t;

    typedef struct packed {
        logic accepted;
        logic [1:0] status;
    } rsp_t;

    // classified item from front to back
    typedef struct packed {
        logic in_window;
        logic [NONCE_W-1:0] nonce_high;
        logic [NONCE_W-1:0] nonce_low;
        logic [TIME_W-1:0] current_time;
        logic [EXP_W-1:0] expiry;
    } job_t;

endpackage

FILE: rtl/nrg_front.sv
module nrg_front (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  nrg_pkg::req_t s_data,
    input  logic [nrg_pkg::SKEW_W-1:0] max_skew,
    output logic q_valid,
    input  logic q_ready,
    output nrg_pkg::job_t q_data
);
    // two-entry queue
    nrg_pkg::job_t q_mem_reg [2];
    logic rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    nrg_pkg::job_t job;
    logic [nrg_pkg::TIME_W-1:0] diff;
    logic push, pop;

    always_comb begin
        if (s_data.current_time >= s_data.request_time) begin
            diff = s_data.current_time - s_data.request_time;
        end else begin
            diff = s_data.request_time - s_data.current_time;
        end
        job.in_window = diff <= {{(nrg_pkg::TIME_W-nrg_pkg::SKEW_W){1'b0}}, max_skew};
        job.nonce_high = s_data.nonce_high;
        job.nonce_low = s_data.nonce_low;
        job.current_time = s_data.current_time;
        job.expiry = {1'b0, s_data.current_time}
                   + {{(nrg_pkg::EXP_W-nrg_pkg::SKEW_W-1){1'b0}}, max_skew, 1'b0};
    end

    assign s_ready = cnt_reg != 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data = q_mem_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= job;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> cnt_reg == $past(cnt_reg) - 2'd1) else $error("pop count");
endmodule

FILE: rtl/nrg_back.sv
module nrg_back #(
    parameter int ENTRIES = nrg_pkg::ENTRIES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  nrg_pkg::job_t q_data,
    output logic m_valid,
    input  logic m_ready,
    output nrg_pkg::rsp_t m_data
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CHK = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [nrg_pkg::NONCE_W-1:0] hi_mem [ENTRIES];
    logic [nrg_pkg::NONCE_W-1:0] lo_mem [ENTRIES];
    logic [nrg_pkg::EXP_W-1:0] exp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic [2:0] state_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [nrg_pkg::NONCE_W-1:0] rd_hi_reg, rd_lo_reg;
    logic [nrg_pkg::EXP_W-1:0] rd_exp_reg;
    logic seen_reg, free_found_reg;
    logic [IW-1:0] free_reg;
    nrg_pkg::job_t job_reg;
    logic out_valid_reg;
    nrg_pkg::rsp_t out_reg;
    logic last_read;
    logic live;
    logic load_out;
    logic [1:0] st;

    assign q_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
    assign last_read = idx_reg == LAST;
    assign live = valid_reg[rd_idx_reg]
               && !(rd_exp_reg < {1'b0, job_reg.current_time});
    assign load_out = state_reg == S_OUT && (!out_valid_reg || m_ready);

    always_comb begin
        if (seen_reg) st = nrg_pkg::ST_REPLAY;
        else if (!free_found_reg) st = nrg_pkg::ST_FULL;
        else st = nrg_pkg::ST_OK;
    end

    // registered reads and insert writes
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            rd_hi_reg <= hi_mem[idx_reg[IW-1:0]];
            rd_lo_reg <= lo_mem[idx_reg[IW-1:0]];
            rd_exp_reg <= exp_mem[idx_reg[IW-1:0]];
            rd_idx_reg <= idx_reg[IW-1:0];
        end
        if (state_reg == S_DONE && !seen_reg && free_found_reg) begin
            hi_mem[free_reg] <= job_reg.nonce_high;
            lo_mem[free_reg] <= job_reg.nonce_low;
            exp_mem[free_reg] <= job_reg.expiry;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) job_reg <= q_data;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            idx_reg <= '0;
            seen_reg <= 1'b0;
            free_found_reg <= 1'b0;
            free_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end else begin
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        idx_reg <= '0;
                        seen_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg <= q_data.in_window ? S_READ : S_OUT;
                    end
                end
                S_READ: begin
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    // expire, match, first free
                    if (!live) valid_reg[rd_idx_reg] <= 1'b0;
                    if (live && rd_hi_reg == job_reg.nonce_high
                        && rd_lo_reg == job_reg.nonce_low) begin
                        seen_reg <= 1'b1;
                    end
                    if (!live && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_reg <= rd_idx_reg;
                    end
                    if (last_read) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_READ;
                    end
                end
                S_DONE: begin
                    if (!seen_reg && free_found_reg) valid_reg[free_reg] <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) begin
                        if (!job_reg.in_window) begin
                            out_reg.status <= nrg_pkg::ST_WINDOW;
                            out_reg.accepted <= 1'b0;
                        end else begin
                            out_reg.status <= st;
                            out_reg.accepted <= st == nrg_pkg::ST_OK;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ok_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.accepted == (m_data.status == nrg_pkg::ST_OK))
        else $error("accepted flag mismatch");
    a_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !seen_reg && free_found_reg |=> valid_reg[$past(free_reg)])
        else $error("insert lost");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
endmodule

FILE: rtl/nonce_replay_guard.sv
// Nonce replay guard. Each item carries a 128-bit nonce, a claimed time and
// the present time (seconds). Items whose times differ by more than max_skew
// (APB register 0, reset 30) get status 1 at once. Others scan the whole
// table: expired entries are freed, a live match gives status 2, else the
// nonce goes into the lowest free entry with expiry now + 2*max_skew and
// status 0; no free entry gives status 3. A front stage checks the window
// into a two-item queue; the back end walks the table one entry at a time,
// each by a registered memory read and then a compare, and takes the next
// item only once its result is loaded. Entry valid bits clear at reset, so
// no clearing pass is needed.
module nonce_replay_guard #(
    parameter int ENTRIES = nrg_pkg::ENTRIES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  nrg_pkg::req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output nrg_pkg::rsp_t m_data,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam logic [2:0] ADDR_SKEW = 3'd0;

    logic [nrg_pkg::SKEW_W-1:0] skew_reg;
    logic q_valid, q_ready;
    nrg_pkg::job_t q_data;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SKEW)
                  ? {{(32-nrg_pkg::SKEW_W){1'b0}}, skew_reg} : 32'd0;

    // register write at the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skew_reg <= nrg_pkg::SKEW_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_SKEW) begin
            skew_reg <= pwdata[nrg_pkg::SKEW_W-1:0];
        end
    end

    nrg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .max_skew(skew_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    nrg_back #(.ENTRIES(ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
